[hw/rtl/bcfm_pkg.sv]
// Shared types and constants for the battery CAN frame monitor.
// Used by bcfm_front, bcfm_queue, bcfm_back and the top level; no dependencies.
`default_nettype none

package bcfm_pkg;

  // Field widths
  localparam int ID_W       = 29;
  localparam int PAYLOAD_W  = 64;
  localparam int TIME_W     = 32;
  localparam int WINDOW_W   = 16;
  localparam int CELL_W     = 16;
  localparam int SUM_W      = 22;
  localparam int CHARGE_W   = 8;

  // Cell frame IDs step by 0x10000 from the base ID
  localparam int STRIDE_SHIFT = 16;
  // Frame index after range checks (at most 16 frames)
  localparam int FRAME_W      = 4;

  // Stream widths
  localparam int S_TDATA_W  = 128;
  localparam int M_TDATA_W  = 120;
  localparam int M_TUSER_W  = 3;
  localparam int OUT_BITS   = 3 + SUM_W + 5 * CELL_W + CHARGE_W;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 29;

  localparam logic [CFG_ADDR_W-1:0] REG_CELL_BASE   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CELL_LAST   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TEMP_ID     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CHARGE_ID   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW      = 3'd4;

  localparam logic [ID_W-1:0]     CELL_BASE_RESET = 29'h1811F401;
  localparam logic [ID_W-1:0]     CELL_LAST_RESET = 29'h1819F401;
  localparam logic [ID_W-1:0]     TEMP_ID_RESET   = 29'h1807F401;
  localparam logic [ID_W-1:0]     CHARGE_ID_RESET = 29'h1808F401;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET    = 16'd1000;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    KIND_CELL    = 2'd0,
    KIND_TEMP    = 2'd1,
    KIND_CHARGE  = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_WRITE,
    BK_WALK,
    BK_DRAIN,
    BK_STATS,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic [ID_W-1:0] cell_first;
    logic [ID_W-1:0] cell_last;
    logic [ID_W-1:0] temp_id;
    logic [ID_W-1:0] charge_id;
  } id_cfg_t;

  typedef struct packed {
    kind_t                kind;
    logic                 err;
    logic [FRAME_W-1:0]   frame;
    logic [PAYLOAD_W-1:0] payload;
    logic [TIME_W-1:0]    now;
  } cmd_t;

  typedef struct packed {
    kind_t               kind;
    logic                err;
    logic                cells_ok;
    logic                temps_ok;
    logic                charge_ok;
    logic [SUM_W-1:0]    pack_sum_mv;
    logic [CELL_W-1:0]   min_cell_mv;
    logic [CELL_W-1:0]   max_cell_mv;
    logic [CELL_W-1:0]   spread_mv;
    logic [CELL_W-1:0]   probe_one_raw;
    logic [CELL_W-1:0]   probe_two_raw;
    logic [CHARGE_W-1:0] charge_raw;
  } result_t;

  // Four little-endian cells of one payload, cell i at bits 16i+15..16i
  typedef logic [3:0][CELL_W-1:0] cell_vec_t;

endpackage

`default_nettype wire

[hw/rtl/bcfm_front.sv]
// Front end: accepts frames from the input stream and classifies them by ID.
// Depends on bcfm_pkg; pushes one command per frame into bcfm_queue.
`default_nettype none

module bcfm_front #(
  parameter int VOLTAGE_FRAMES = 9
) (
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [bcfm_pkg::S_TDATA_W-1:0] s_tdata,
  input  wire bcfm_pkg::id_cfg_t              ids,
  input  wire logic                           q_full,
  output logic                                q_push,
  output bcfm_pkg::cmd_t                      q_cmd
);
  import bcfm_pkg::*;

  localparam int FRAME_HI_W = ID_W - STRIDE_SHIFT;

  logic [ID_W-1:0]       id;
  logic [PAYLOAD_W-1:0]  payload;
  logic [TIME_W-1:0]     now;
  logic [ID_W-1:0]       off;
  logic [FRAME_HI_W-1:0] frame_hi;
  logic                  in_range;
  logic                  misaligned;
  logic                  frame_over;

  // Unpack the frame fields
  assign id      = s_tdata[ID_W-1:0];
  assign payload = s_tdata[ID_W +: PAYLOAD_W];
  assign now     = s_tdata[ID_W + PAYLOAD_W +: TIME_W];

  // Accept whenever the queue has room
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  // Offset into the cell ID range, modulo 2^29
  assign off        = id - ids.cell_first;
  assign frame_hi   = off[ID_W-1:STRIDE_SHIFT];
  assign in_range   = (id >= ids.cell_first) && (id <= ids.cell_last);
  assign misaligned = off[STRIDE_SHIFT-1:0] != '0;
  assign frame_over = frame_hi >= FRAME_HI_W'(VOLTAGE_FRAMES);

  // Classify: cell range first, then temperature, then charge state
  always_comb begin
    q_cmd.payload = payload;
    q_cmd.now     = now;
    q_cmd.frame   = frame_hi[FRAME_W-1:0];
    q_cmd.err     = 1'b0;
    if (in_range) begin
      q_cmd.kind = KIND_CELL;
      q_cmd.err  = misaligned || frame_over;
    end else if (id == ids.temp_id) begin
      q_cmd.kind = KIND_TEMP;
    end else if (id == ids.charge_id) begin
      q_cmd.kind = KIND_CHARGE;
      q_cmd.err  = payload[55:48] == '0;
    end else begin
      q_cmd.kind = KIND_UNKNOWN;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bcfm_queue.sv]
// Short command queue that decouples the front end from the back end.
// Depends on bcfm_pkg for the command type and depth.
`default_nettype none

module bcfm_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire bcfm_pkg::cmd_t din,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output bcfm_pkg::cmd_t      dout
);
  import bcfm_pkg::*;

  cmd_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = count == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign valid = count != '0;
  assign dout  = entry[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bcfm_back.sv]
// Back end: applies one queued command, holds the cell store and the held values,
// and walks the store for sum, min and max. Depends on bcfm_pkg.
`default_nettype none

module bcfm_back #(
  parameter int CELL_COUNT      = 36,
  parameter int CELLS_PER_FRAME = 4,
  parameter int VOLTAGE_FRAMES  = 9
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire bcfm_pkg::cmd_t                q_data,
  output logic                               q_pop,
  input  wire logic [bcfm_pkg::WINDOW_W-1:0] window,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output bcfm_pkg::result_t                  out_res
);
  import bcfm_pkg::*;

  localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int CNT_W  = (CELLS_PER_FRAME > 1) ? $clog2(CELLS_PER_FRAME) : 1;
  localparam int SLOT_W = $clog2(VOLTAGE_FRAMES * CELLS_PER_FRAME + CELL_COUNT + 1);

  back_state_t state, state_next;
  cmd_t        cmd;

  logic [CNT_W-1:0]  wr_cnt;
  logic [ADDR_W-1:0] walk_addr;
  logic              rd_pend;
  logic              write_last;
  logic              walk_last;
  logic              out_load;

  // Cell store and its valid bits
  logic [CELL_W-1:0]     cell_mem [CELL_COUNT];
  logic [CELL_COUNT-1:0] cell_vld;
  logic [CELL_W-1:0]     rd_data;
  logic                  rd_vld;
  logic [CELL_W-1:0]     rd_value;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [CELL_W-1:0]     mem_wdata;
  logic [SLOT_W-1:0]     slot;
  cell_vec_t             pl_cells;

  // Walk accumulators
  logic [SUM_W-1:0]  acc_sum;
  logic [CELL_W-1:0] acc_min;
  logic [CELL_W-1:0] acc_max;

  // Held state
  logic [TIME_W-1:0]   last_time;
  logic [TIME_W-1:0]   gap;
  logic                cells_flag;
  logic                temps_flag;
  logic                charge_flag;
  logic [CELL_W-1:0]   probe_one;
  logic [CELL_W-1:0]   probe_two;
  logic [CHARGE_W-1:0] charge;
  logic [SUM_W-1:0]    pack_sum;
  logic [CELL_W-1:0]   min_cell;
  logic [CELL_W-1:0]   max_cell;
  logic [CELL_W-1:0]   spread;

  assign pl_cells   = cmd.payload;
  assign slot       = SLOT_W'(cmd.frame) * SLOT_W'(CELLS_PER_FRAME) + SLOT_W'(wr_cnt);
  assign write_last = wr_cnt == CNT_W'(CELLS_PER_FRAME - 1);
  assign walk_last  = walk_addr == ADDR_W'(CELL_COUNT - 1);
  assign gap        = q_data.now - last_time;
  assign rd_value   = rd_vld ? rd_data : '0;
  assign mem_waddr  = slot[ADDR_W-1:0];
  assign mem_wdata  = pl_cells[2'(wr_cnt)];

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    out_load   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_data.kind == KIND_CELL && !q_data.err) begin
            state_next = BK_WRITE;
          end else begin
            state_next = BK_DONE;
          end
        end
      end
      BK_WRITE: begin
        // drop slots past the end of the store
        mem_we = slot < SLOT_W'(CELL_COUNT);
        if (write_last) begin
          state_next = cells_flag ? BK_WALK : BK_DONE;
        end
      end
      BK_WALK: begin
        if (walk_last) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: state_next = BK_STATS;
      BK_STATS: state_next = BK_DONE;
      BK_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Write and walk counters
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_cnt    <= '0;
      walk_addr <= '0;
      rd_pend   <= 1'b0;
    end else begin
      wr_cnt    <= (state == BK_WRITE) ? wr_cnt + 1'b1 : '0;
      walk_addr <= (state == BK_WALK) ? walk_addr + 1'b1 : '0;
      rd_pend   <= state == BK_WALK;
    end
  end

  // Latch the popped command
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_data;
    end
  end

  // Cell store write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= cell_mem[walk_addr];
  end

  // Valid bits: an unwritten cell reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_vld <= '0;
      rd_vld   <= 1'b0;
    end else begin
      if (mem_we) begin
        cell_vld[mem_waddr] <= 1'b1;
      end
      rd_vld <= cell_vld[walk_addr];
    end
  end

  // Accumulate sum, min and max over the walk
  always_ff @(posedge clk) begin
    if (state == BK_WRITE) begin
      acc_sum <= '0;
      acc_min <= '1;
      acc_max <= '0;
    end else if (rd_pend) begin
      acc_sum <= acc_sum + SUM_W'(rd_value);
      if (rd_value < acc_min) begin
        acc_min <= rd_value;
      end
      if (rd_value > acc_max) begin
        acc_max <= rd_value;
      end
    end
  end

  // Update held values and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time   <= '0;
      cells_flag  <= 1'b0;
      temps_flag  <= 1'b0;
      charge_flag <= 1'b0;
      probe_one   <= '0;
      probe_two   <= '0;
      charge      <= '0;
      pack_sum    <= '0;
      min_cell    <= '0;
      max_cell    <= '0;
      spread      <= '0;
    end else begin
      if (q_pop) begin
        case (q_data.kind)
          KIND_CELL: begin
            if (!q_data.err) begin
              cells_flag <= gap <= TIME_W'(window);
              last_time  <= q_data.now;
            end
          end
          KIND_TEMP: begin
            probe_one  <= q_data.payload[31:16];
            probe_two  <= {q_data.payload[39:32], q_data.payload[47:40]};
            temps_flag <= 1'b1;
          end
          KIND_CHARGE: begin
            if (!q_data.err) begin
              charge      <= q_data.payload[55:48];
              charge_flag <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (state == BK_STATS) begin
        pack_sum <= acc_sum;
        min_cell <= acc_min;
        max_cell <= acc_max;
        spread   <= acc_max - acc_min;
      end
    end
  end

  // Output register: hold a result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res.kind          <= cmd.kind;
      out_res.err           <= cmd.err;
      out_res.cells_ok      <= cells_flag;
      out_res.temps_ok      <= temps_flag;
      out_res.charge_ok     <= charge_flag;
      out_res.pack_sum_mv   <= pack_sum;
      out_res.min_cell_mv   <= min_cell;
      out_res.max_cell_mv   <= max_cell;
      out_res.spread_mv     <= spread;
      out_res.probe_one_raw <= probe_one;
      out_res.probe_two_raw <= probe_two;
      out_res.charge_raw    <= charge;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/battery_can_frame_monitor.sv]
// Flow, input to result transfer: frames that write no cells go from the queue to the
// output register; a cell frame first writes CELLS_PER_FRAME cells (BK_WRITE), and while
// cells are valid the back end then walks the cell store (BK_WALK, BK_DRAIN, BK_STATS) for the stats.
// The back end takes one frame at a time; a 2-entry queue takes frames meanwhile.
// Reset (rst, synchronous) restores register defaults, clears flags, held values and valid bits.
`default_nettype none

module battery_can_frame_monitor #(
  parameter int CELL_COUNT      = 36,
  parameter int CELLS_PER_FRAME = 4,
  parameter int VOLTAGE_FRAMES  = 9
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // can_id [28:0], payload [92:29], now_ms [124:93], zero pad
  input  wire logic [bcfm_pkg::S_TDATA_W-1:0]  s_tdata,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // cells_ok, temps_ok, charge_ok, pack_sum_mv, min_cell_mv, max_cell_mv,
  // spread_mv, probe_one_raw, probe_two_raw, charge_raw, zero pad
  output logic [bcfm_pkg::M_TDATA_W-1:0]       m_tdata,
  // frame_kind [1:0], decode_error [2]
  output logic [bcfm_pkg::M_TUSER_W-1:0]       m_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  input  wire logic                            cfg_we,
  input  wire logic [bcfm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [bcfm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bcfm_pkg::*;

  id_cfg_t             ids;
  logic [WINDOW_W-1:0] window;
  logic                q_full;
  logic                q_push;
  cmd_t                q_cmd;
  logic                q_pop;
  logic                q_valid;
  cmd_t                q_data;
  result_t             res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ids.cell_first <= CELL_BASE_RESET;
      ids.cell_last  <= CELL_LAST_RESET;
      ids.temp_id    <= TEMP_ID_RESET;
      ids.charge_id  <= CHARGE_ID_RESET;
      window         <= WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CELL_BASE: ids.cell_first <= cfg_wdata[ID_W-1:0];
        REG_CELL_LAST: ids.cell_last  <= cfg_wdata[ID_W-1:0];
        REG_TEMP_ID:   ids.temp_id    <= cfg_wdata[ID_W-1:0];
        REG_CHARGE_ID: ids.charge_id  <= cfg_wdata[ID_W-1:0];
        REG_WINDOW:    window         <= cfg_wdata[WINDOW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bcfm_front #(
    .VOLTAGE_FRAMES(VOLTAGE_FRAMES)
  ) u_front (
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .ids     (ids),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  bcfm_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_cmd),
    .full (q_full),
    .pop  (q_pop),
    .valid(q_valid),
    .dout (q_data)
  );

  bcfm_back #(
    .CELL_COUNT     (CELL_COUNT),
    .CELLS_PER_FRAME(CELLS_PER_FRAME),
    .VOLTAGE_FRAMES (VOLTAGE_FRAMES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .window   (window),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_res  (res)
  );

  // Pack the result onto the output stream
  assign m_tuser = {res.err, res.kind};
  assign m_tdata = {{(M_TDATA_W - OUT_BITS){1'b0}},
                    res.charge_raw, res.probe_two_raw, res.probe_one_raw,
                    res.spread_mv, res.max_cell_mv, res.min_cell_mv,
                    res.pack_sum_mv, res.charge_ok, res.temps_ok, res.cells_ok};

`ifndef SYNTHESIS
  a_spread: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res.spread_mv == CELL_W'(res.max_cell_mv - res.min_cell_mv))
    else $error("spread does not match max minus min");

  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.err) |-> (res.kind == KIND_CELL || res.kind == KIND_CHARGE))
    else $error("decode error on a frame kind that cannot fail");

  a_charge: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.charge_ok) |-> res.charge_raw != '0)
    else $error("charge state flagged valid with a zero byte");

  a_min_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res.min_cell_mv <= res.max_cell_mv)
    else $error("minimum cell above maximum cell");
`endif

endmodule

`default_nettype wire
